// File: rtl/msc4k_pkg.sv
// msc4k_pkg: shared types, opcodes and constants of the scalar core
// no dependencies
package msc4k_pkg;

  localparam int unsigned DATA_BYTES_DEF = 4096;
  localparam logic [11:0] PC_MASK        = 12'hFFC;

  // host item kinds
  typedef enum logic [1:0] {
    OP_EXEC    = 2'd0,
    OP_HWRITE  = 2'd1,
    OP_HREAD   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  // result codes
  typedef enum logic [1:0] {
    OUT_DONE     = 2'd0,
    OUT_RESERVED = 2'd1,
    OUT_COPROC   = 2'd2,
    OUT_HALTED   = 2'd3
  } outcome_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_MEM  = 2'd2
  } state_e;

  // configuration register indexes
  localparam logic CFG_START_ADDR   = 1'b0;
  localparam logic CFG_IRQ_ON_BREAK = 1'b1;

  // primary opcodes
  localparam logic [5:0] OPC_SPECIAL = 6'h00;
  localparam logic [5:0] OPC_REGIMM  = 6'h01;
  localparam logic [5:0] OPC_J       = 6'h02;
  localparam logic [5:0] OPC_JAL     = 6'h03;
  localparam logic [5:0] OPC_BEQ     = 6'h04;
  localparam logic [5:0] OPC_BNE     = 6'h05;
  localparam logic [5:0] OPC_BLEZ    = 6'h06;
  localparam logic [5:0] OPC_BGTZ    = 6'h07;
  localparam logic [5:0] OPC_ADDI    = 6'h08;
  localparam logic [5:0] OPC_ADDIU   = 6'h09;
  localparam logic [5:0] OPC_SLTI    = 6'h0A;
  localparam logic [5:0] OPC_SLTIU   = 6'h0B;
  localparam logic [5:0] OPC_ANDI    = 6'h0C;
  localparam logic [5:0] OPC_ORI     = 6'h0D;
  localparam logic [5:0] OPC_XORI    = 6'h0E;
  localparam logic [5:0] OPC_LUI     = 6'h0F;
  localparam logic [5:0] OPC_COP0    = 6'h10;
  localparam logic [5:0] OPC_COP2    = 6'h12;
  localparam logic [5:0] OPC_LB      = 6'h20;
  localparam logic [5:0] OPC_LH      = 6'h21;
  localparam logic [5:0] OPC_LW      = 6'h23;
  localparam logic [5:0] OPC_LBU     = 6'h24;
  localparam logic [5:0] OPC_LHU     = 6'h25;
  localparam logic [5:0] OPC_SB      = 6'h28;
  localparam logic [5:0] OPC_SH      = 6'h29;
  localparam logic [5:0] OPC_SW      = 6'h2B;
  localparam logic [5:0] OPC_LWC2    = 6'h32;
  localparam logic [5:0] OPC_SWC2    = 6'h3A;

  // special function codes
  localparam logic [5:0] FN_SLL   = 6'h00;
  localparam logic [5:0] FN_SRL   = 6'h02;
  localparam logic [5:0] FN_SRA   = 6'h03;
  localparam logic [5:0] FN_SLLV  = 6'h04;
  localparam logic [5:0] FN_SRLV  = 6'h06;
  localparam logic [5:0] FN_SRAV  = 6'h07;
  localparam logic [5:0] FN_JR    = 6'h08;
  localparam logic [5:0] FN_JALR  = 6'h09;
  localparam logic [5:0] FN_BREAK = 6'h0D;
  localparam logic [5:0] FN_ADD   = 6'h20;
  localparam logic [5:0] FN_ADDU  = 6'h21;
  localparam logic [5:0] FN_SUB   = 6'h22;
  localparam logic [5:0] FN_SUBU  = 6'h23;
  localparam logic [5:0] FN_AND   = 6'h24;
  localparam logic [5:0] FN_OR    = 6'h25;
  localparam logic [5:0] FN_XOR   = 6'h26;
  localparam logic [5:0] FN_NOR   = 6'h27;
  localparam logic [5:0] FN_SLT   = 6'h2A;
  localparam logic [5:0] FN_SLTU  = 6'h2B;

  // regimm codes
  localparam logic [4:0] RI_BLTZ   = 5'h00;
  localparam logic [4:0] RI_BGEZ   = 5'h01;
  localparam logic [4:0] RI_BLTZAL = 5'h10;
  localparam logic [4:0] RI_BGEZAL = 5'h11;

  // decoded effect of one instruction
  typedef struct packed {
    outcome_e    outcome;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        take;
    logic [11:0] target;
    logic        brk;
    logic        mem_rd;
    logic        mem_wr;
    logic [1:0]  nbytes_m1;
    logic [31:0] ea;
    logic [31:0] st_data;
  } exec_res_t;

endpackage

// File: rtl/mips_scalar_core_4k_memory.sv
// mips_scalar_core_4k_memory: top level of the scalar integer core
// depends on msc4k_pkg, msc4k_ram, msc4k_dmem, msc4k_exec
//
// Usage:
//   A word is offered on operation_i/instruction_i/host_word_index_i/host_data_i
//   and taken at a rising edge with start high and busy low. Each word gives
//   exactly one result, shown for one cycle with done_o high; the receiver
//   cannot hold it off, and the core may take the next word in that cycle.
//   Execute words carry the instruction fetched at the fetch_address_o last
//   reported. Host writes/reads move one data memory word; restart loads the
//   pc from the start address register and clears the halt flag.
//   done_o is registered; loads and host reads also pass the S_MEM state for
//   the registered read of the byte-banked data memory, which follows the
//   registered read of the register file rams.
//   The core takes no new word while busy; the next can start in the
//   cycle done_o is shown.
//   Reset: registers read as zero, pc is 0, the core is halted until a restart
//   word; data memory content is undefined until written.
//   Configuration writes (cfg_we_i) take effect at any edge with cfg_we_i high;
//   they are meant to be made only while no word is in flight.
module mips_scalar_core_4k_memory #(
  parameter int unsigned DATA_BYTES = msc4k_pkg::DATA_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation_i,
  input  logic [31:0] instruction_i,
  input  logic [9:0]  host_word_index_i,
  input  logic [31:0] host_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        done_o,
  output logic [11:0] fetch_address_o,
  output logic        halted_o,
  output logic        interrupt_raised_o,
  output logic [1:0]  outcome_o,
  output logic [31:0] read_data_o
);

  localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
  localparam int unsigned ROW_W  = ADDR_W - 2;

  msc4k_pkg::state_e   state_q, state_d;
  msc4k_pkg::op_e      op_q;
  msc4k_pkg::outcome_e outcome_q, outcome_d;
  msc4k_pkg::exec_res_t res;

  logic [31:0] instr_q;
  logic [9:0]  hidx_q;
  logic [31:0] hdata_q;
  logic [11:0] pc_q, pc_d;
  logic [1:0]  bp_q, bp_d, bp_eff;
  logic [11:0] bt_q, bt_d;
  logic        halt_q, halt_d;
  logic [11:0] start_addr_q;
  logic        irq_en_q;
  logic [31:0] rf_valid_q;
  logic        done_q, done_d;
  logic        irq_q, irq_d;
  logic [31:0] rdata_q, rdata_d;

  logic        accept;
  logic        run;
  logic [31:0] rf_a_raw, rf_b_raw, a_val, b_val;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic        dm_we;
  logic [ADDR_W-1:0] dm_addr;
  logic [1:0]  dm_nbm1;
  logic [31:0] dm_wdata, dm_rdata;
  logic [31:0] ld_val;

  assign accept = start && (state_q == msc4k_pkg::S_IDLE);
  assign busy   = state_q != msc4k_pkg::S_IDLE;
  assign run    = (state_q == msc4k_pkg::S_EXEC) && (op_q == msc4k_pkg::OP_EXEC) && !halt_q;

  // register file: two copies for two read ports, valid bits give zero reset
  msc4k_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(instruction_i[25:21]), .rdata_o(rf_a_raw)
  );
  msc4k_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk_i(clk_i), .we_i(rf_we), .waddr_i(rf_waddr), .wdata_i(rf_wdata),
    .raddr_i(instruction_i[20:16]), .rdata_o(rf_b_raw)
  );

  assign a_val = rf_valid_q[instr_q[25:21]] ? rf_a_raw : 32'd0;
  assign b_val = rf_valid_q[instr_q[20:16]] ? rf_b_raw : 32'd0;

  msc4k_exec u_exec (
    .instr_i(instr_q),
    .a_i    (a_val),
    .b_i    (b_val),
    .pc_i   (pc_q),
    .res_o  (res)
  );

  msc4k_dmem #(.DATA_BYTES(DATA_BYTES)) u_dmem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (state_q == msc4k_pkg::S_EXEC),
    .we_i       (dm_we),
    .addr_i     (dm_addr),
    .nbytes_m1_i(dm_nbm1),
    .wdata_i    (dm_wdata),
    .rdata_o    (dm_rdata)
  );

  // load extension
  always_comb begin
    unique case (instr_q[31:26])
      msc4k_pkg::OPC_LB:  ld_val = {{24{dm_rdata[31]}}, dm_rdata[31:24]};
      msc4k_pkg::OPC_LBU: ld_val = {24'd0, dm_rdata[31:24]};
      msc4k_pkg::OPC_LH:  ld_val = {{16{dm_rdata[31]}}, dm_rdata[31:16]};
      msc4k_pkg::OPC_LHU: ld_val = {16'd0, dm_rdata[31:16]};
      default:            ld_val = dm_rdata;
    endcase
  end

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = res.rf_waddr;
    rf_wdata = res.rf_wdata;
    if (run) begin
      rf_we = res.rf_we;
    end else if (state_q == msc4k_pkg::S_MEM && op_q == msc4k_pkg::OP_EXEC) begin
      rf_we    = 1'b1;
      rf_waddr = instr_q[20:16];
      rf_wdata = ld_val;
    end
    if (rf_waddr == 5'd0) begin
      rf_we = 1'b0;
    end
  end

  // data memory port
  always_comb begin
    if (op_q == msc4k_pkg::OP_HWRITE || op_q == msc4k_pkg::OP_HREAD) begin
      dm_addr  = {ROW_W'(hidx_q), 2'b00};
      dm_nbm1  = 2'd3;
      dm_wdata = hdata_q;
      dm_we    = (state_q == msc4k_pkg::S_EXEC) && (op_q == msc4k_pkg::OP_HWRITE);
    end else begin
      dm_addr  = res.ea[ADDR_W-1:0];
      dm_nbm1  = res.nbytes_m1;
      dm_wdata = res.st_data;
      dm_we    = run && res.mem_wr;
    end
  end

  // pc, delay slot and halt state
  always_comb begin
    pc_d   = pc_q;
    bp_d   = bp_q;
    bt_d   = bt_q;
    halt_d = halt_q;
    bp_eff = res.take ? 2'd1 : bp_q;
    if (run) begin
      if (res.take) begin
        bt_d = res.target & msc4k_pkg::PC_MASK;
      end
      if (bp_eff == 2'd2) begin
        bp_d = 2'd0;
        pc_d = bt_q & msc4k_pkg::PC_MASK;
      end else begin
        bp_d = (bp_eff != 2'd0) ? 2'd2 : 2'd0;
        pc_d = (pc_q + 12'd4) & msc4k_pkg::PC_MASK;
      end
      if (res.brk) begin
        halt_d = 1'b1;
      end
    end else if (state_q == msc4k_pkg::S_EXEC && op_q == msc4k_pkg::OP_RESTART) begin
      pc_d   = start_addr_q & msc4k_pkg::PC_MASK;
      bp_d   = 2'd0;
      halt_d = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msc4k_pkg::S_IDLE: if (accept) state_d = msc4k_pkg::S_EXEC;
      msc4k_pkg::S_EXEC: begin
        if ((run && res.mem_rd) || op_q == msc4k_pkg::OP_HREAD) begin
          state_d = msc4k_pkg::S_MEM;
        end else begin
          state_d = msc4k_pkg::S_IDLE;
        end
      end
      msc4k_pkg::S_MEM: state_d = msc4k_pkg::S_IDLE;
      default: state_d = msc4k_pkg::S_IDLE;
    endcase
  end

  // result word
  always_comb begin
    done_d    = 1'b0;
    outcome_d = msc4k_pkg::OUT_DONE;
    irq_d     = 1'b0;
    rdata_d   = 32'd0;
    unique case (state_q)
      msc4k_pkg::S_EXEC: begin
        if (op_q == msc4k_pkg::OP_EXEC) begin
          if (halt_q) begin
            done_d    = 1'b1;
            outcome_d = msc4k_pkg::OUT_HALTED;
          end else begin
            done_d    = !res.mem_rd;
            outcome_d = res.outcome;
            irq_d     = res.brk && irq_en_q;
          end
        end else begin
          done_d = op_q != msc4k_pkg::OP_HREAD;
        end
      end
      msc4k_pkg::S_MEM: begin
        done_d = 1'b1;
        if (op_q == msc4k_pkg::OP_HREAD) begin
          rdata_d = dm_rdata;
        end
      end
      default: done_d = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= msc4k_pkg::S_IDLE;
      pc_q       <= 12'd0;
      bp_q       <= 2'd0;
      bt_q       <= 12'd0;
      halt_q     <= 1'b1;
      rf_valid_q <= 32'd0;
      done_q     <= 1'b0;
      irq_q      <= 1'b0;
      outcome_q  <= msc4k_pkg::OUT_DONE;
      rdata_q    <= 32'd0;
      start_addr_q <= 12'd0;
      irq_en_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      pc_q      <= pc_d;
      bp_q      <= bp_d;
      bt_q      <= bt_d;
      halt_q    <= halt_d;
      done_q    <= done_d;
      irq_q     <= irq_d;
      outcome_q <= outcome_d;
      rdata_q   <= rdata_d;
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          msc4k_pkg::CFG_START_ADDR:   start_addr_q <= cfg_data_i;
          msc4k_pkg::CFG_IRQ_ON_BREAK: irq_en_q     <= cfg_data_i[0];
          default:                     irq_en_q     <= irq_en_q;
        endcase
      end
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= msc4k_pkg::op_e'(operation_i);
      instr_q <= instruction_i;
      hidx_q  <= host_word_index_i;
      hdata_q <= host_data_i;
    end
  end

  assign done_o             = done_q;
  assign fetch_address_o    = pc_q;
  assign halted_o           = halt_q;
  assign interrupt_raised_o = irq_q;
  assign outcome_o          = outcome_q;
  assign read_data_o        = rdata_q;

endmodule

// File: rtl/msc4k_ram.sv
// msc4k_ram: generic single-clock ram, one write and one registered read port
// no dependencies
module msc4k_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/msc4k_dmem.sv
// msc4k_dmem: byte-banked big-endian data memory, any alignment in one access
// depends on msc4k_ram
module msc4k_dmem #(
  parameter int unsigned DATA_BYTES = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_i,
  input  logic                          we_i,
  input  logic [$clog2(DATA_BYTES)-1:0] addr_i,
  input  logic [1:0]                    nbytes_m1_i,
  input  logic [31:0]                   wdata_i,
  output logic [31:0]                   rdata_o
);

  localparam int unsigned ADDR_W = $clog2(DATA_BYTES);
  localparam int unsigned ROW_W  = ADDR_W - 2;
  localparam int unsigned ROWS   = DATA_BYTES / 4;

  logic [31:0] wshift;
  logic [7:0]  bank_rdata [4];
  logic [1:0]  lo_q;

  // left-align the store word so byte k sits at bits 31-8k
  assign wshift = wdata_i << {2'd3 - nbytes_m1_i, 3'b000};

  for (genvar j = 0; j < 4; j++) begin : g_bank
    logic [1:0]       k;
    logic [ROW_W-1:0] row;
    logic             bwe;
    logic [31:0]      bsel;

    // byte k of the access lands in this bank, one row up when it wraps past
    assign k    = 2'(j) - addr_i[1:0];
    assign row  = addr_i[ADDR_W-1:2] + ROW_W'(2'(j) < addr_i[1:0]);
    assign bwe  = we_i && (k <= nbytes_m1_i);
    assign bsel = wshift >> {2'd3 - k, 3'b000};

    msc4k_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_bank (
      .clk_i  (clk_i),
      .we_i   (bwe),
      .waddr_i(row),
      .wdata_i(bsel[7:0]),
      .raddr_i(row),
      .rdata_o(bank_rdata[j])
    );
  end

  // remember the byte offset for read assembly
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= 2'd0;
    end else if (req_i) begin
      lo_q <= addr_i[1:0];
    end
  end

  // big-endian word from the four banks
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      rdata_o[31-8*k -: 8] = bank_rdata[lo_q + 2'(k)];
    end
  end

endmodule

// File: rtl/msc4k_exec.sv
// msc4k_exec: instruction decode, alu, branch and address calculation
// depends on msc4k_pkg
module msc4k_exec (
  input  logic [31:0]          instr_i,
  input  logic [31:0]          a_i,
  input  logic [31:0]          b_i,
  input  logic [11:0]          pc_i,
  output msc4k_pkg::exec_res_t res_o
);

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] imm;
  logic [31:0] simm;
  logic [11:0] link;
  logic [11:0] boff;
  logic [11:0] jtgt;
  logic [31:0] sum_i;
  logic        a_neg;

  assign opc   = instr_i[31:26];
  assign fn    = instr_i[5:0];
  assign rt    = instr_i[20:16];
  assign rd    = instr_i[15:11];
  assign sa    = instr_i[10:6];
  assign imm   = {16'd0, instr_i[15:0]};
  assign simm  = {{16{instr_i[15]}}, instr_i[15:0]};
  assign link  = (pc_i + 12'd8) & msc4k_pkg::PC_MASK;
  assign boff  = pc_i + 12'd4 + {instr_i[9:0], 2'b00};
  assign jtgt  = {instr_i[9:0], 2'b00};
  assign sum_i = a_i + simm;
  assign a_neg = a_i[31];

  // decode
  always_comb begin
    res_o           = '0;
    res_o.outcome   = msc4k_pkg::OUT_DONE;
    res_o.ea        = sum_i;
    res_o.st_data   = b_i;
    res_o.rf_waddr  = rt;
    unique case (opc)
      msc4k_pkg::OPC_SPECIAL: begin
        res_o.rf_waddr = rd;
        res_o.rf_we    = 1'b1;
        unique case (fn)
          msc4k_pkg::FN_SLL:  res_o.rf_wdata = b_i << sa;
          msc4k_pkg::FN_SRL:  res_o.rf_wdata = b_i >> sa;
          msc4k_pkg::FN_SRA:  res_o.rf_wdata = $unsigned($signed(b_i) >>> sa);
          msc4k_pkg::FN_SLLV: res_o.rf_wdata = b_i << a_i[4:0];
          msc4k_pkg::FN_SRLV: res_o.rf_wdata = b_i >> a_i[4:0];
          msc4k_pkg::FN_SRAV: res_o.rf_wdata = $unsigned($signed(b_i) >>> a_i[4:0]);
          msc4k_pkg::FN_JR: begin
            res_o.rf_we  = 1'b0;
            res_o.take   = 1'b1;
            res_o.target = a_i[11:0];
          end
          msc4k_pkg::FN_JALR: begin
            res_o.rf_wdata = {20'd0, link};
            res_o.take     = 1'b1;
            res_o.target   = a_i[11:0];
          end
          msc4k_pkg::FN_BREAK: begin
            res_o.rf_we = 1'b0;
            res_o.brk   = 1'b1;
          end
          msc4k_pkg::FN_ADD, msc4k_pkg::FN_ADDU: res_o.rf_wdata = a_i + b_i;
          msc4k_pkg::FN_SUB, msc4k_pkg::FN_SUBU: res_o.rf_wdata = a_i - b_i;
          msc4k_pkg::FN_AND:  res_o.rf_wdata = a_i & b_i;
          msc4k_pkg::FN_OR:   res_o.rf_wdata = a_i | b_i;
          msc4k_pkg::FN_XOR:  res_o.rf_wdata = a_i ^ b_i;
          msc4k_pkg::FN_NOR:  res_o.rf_wdata = ~(a_i | b_i);
          msc4k_pkg::FN_SLT:  res_o.rf_wdata = {31'd0, $signed(a_i) < $signed(b_i)};
          msc4k_pkg::FN_SLTU: res_o.rf_wdata = {31'd0, a_i < b_i};
          default: begin
            res_o.rf_we   = 1'b0;
            res_o.outcome = msc4k_pkg::OUT_RESERVED;
          end
        endcase
      end
      msc4k_pkg::OPC_REGIMM: begin
        res_o.target   = boff;
        res_o.rf_waddr = 5'd31;
        res_o.rf_wdata = {20'd0, link};
        unique case (rt)
          msc4k_pkg::RI_BLTZ: res_o.take = a_neg;
          msc4k_pkg::RI_BGEZ: res_o.take = !a_neg;
          msc4k_pkg::RI_BLTZAL: begin
            res_o.take  = a_neg;
            res_o.rf_we = 1'b1;
          end
          msc4k_pkg::RI_BGEZAL: begin
            res_o.take  = !a_neg;
            res_o.rf_we = 1'b1;
          end
          default: res_o.outcome = msc4k_pkg::OUT_RESERVED;
        endcase
      end
      msc4k_pkg::OPC_J: begin
        res_o.take   = 1'b1;
        res_o.target = jtgt;
      end
      msc4k_pkg::OPC_JAL: begin
        res_o.take     = 1'b1;
        res_o.target   = jtgt;
        res_o.rf_we    = 1'b1;
        res_o.rf_waddr = 5'd31;
        res_o.rf_wdata = {20'd0, link};
      end
      msc4k_pkg::OPC_BEQ: begin
        res_o.take   = a_i == b_i;
        res_o.target = boff;
      end
      msc4k_pkg::OPC_BNE: begin
        res_o.take   = a_i != b_i;
        res_o.target = boff;
      end
      msc4k_pkg::OPC_BLEZ: begin
        res_o.take   = a_neg || (a_i == 32'd0);
        res_o.target = boff;
      end
      msc4k_pkg::OPC_BGTZ: begin
        res_o.take   = !a_neg && (a_i != 32'd0);
        res_o.target = boff;
      end
      msc4k_pkg::OPC_ADDI, msc4k_pkg::OPC_ADDIU: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = sum_i;
      end
      msc4k_pkg::OPC_SLTI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = {31'd0, $signed(a_i) < $signed(simm)};
      end
      msc4k_pkg::OPC_SLTIU: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = {31'd0, a_i < simm};
      end
      msc4k_pkg::OPC_ANDI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = a_i & imm;
      end
      msc4k_pkg::OPC_ORI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = a_i | imm;
      end
      msc4k_pkg::OPC_XORI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = a_i ^ imm;
      end
      msc4k_pkg::OPC_LUI: begin
        res_o.rf_we    = 1'b1;
        res_o.rf_wdata = {instr_i[15:0], 16'd0};
      end
      msc4k_pkg::OPC_COP0, msc4k_pkg::OPC_COP2,
      msc4k_pkg::OPC_LWC2, msc4k_pkg::OPC_SWC2: begin
        res_o.outcome = msc4k_pkg::OUT_COPROC;
      end
      msc4k_pkg::OPC_LB, msc4k_pkg::OPC_LBU: begin
        res_o.mem_rd    = 1'b1;
        res_o.nbytes_m1 = 2'd0;
      end
      msc4k_pkg::OPC_LH, msc4k_pkg::OPC_LHU: begin
        res_o.mem_rd    = 1'b1;
        res_o.nbytes_m1 = 2'd1;
      end
      msc4k_pkg::OPC_LW: begin
        res_o.mem_rd    = 1'b1;
        res_o.nbytes_m1 = 2'd3;
      end
      msc4k_pkg::OPC_SB: begin
        res_o.mem_wr    = 1'b1;
        res_o.nbytes_m1 = 2'd0;
      end
      msc4k_pkg::OPC_SH: begin
        res_o.mem_wr    = 1'b1;
        res_o.nbytes_m1 = 2'd1;
      end
      msc4k_pkg::OPC_SW: begin
        res_o.mem_wr    = 1'b1;
        res_o.nbytes_m1 = 2'd3;
      end
      default: res_o.outcome = msc4k_pkg::OUT_RESERVED;
    endcase
  end

endmodule

// File: rtl/msc4k_checker.sv
// msc4k_checker: port-level assertions for the scalar core, bound to the top
// depends on msc4k_pkg and mips_scalar_core_4k_memory
module msc4k_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       halted_o,
  input logic       interrupt_raised_o,
  input logic [1:0] outcome_o
);

  // a taken word keeps the core busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept without busy");

  // busy ends exactly when the result word shows
  a_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy fell without result");

  // result strobes are never back to back
  a_done_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe repeated");

  // halted results and interrupts imply the halt flag
  a_halt_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (outcome_o == msc4k_pkg::OUT_HALTED || interrupt_raised_o) |-> halted_o)
    else $error("halt flag missing");

endmodule

bind mips_scalar_core_4k_memory msc4k_checker u_msc4k_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .halted_o          (halted_o),
  .interrupt_raised_o(interrupt_raised_o),
  .outcome_o         (outcome_o)
);
